// ===== rtl/stereo_goniometer_accumulator_core_assert.svh =====
// Assertion macros for the stereo goniometer accumulator.
`ifndef STEREO_GONIOMETER_ACCUMULATOR_CORE_ASSERT_SVH
`define STEREO_GONIOMETER_ACCUMULATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SGA_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define SGA_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define SGA_ASSERT(label, cond, msg)
`define SGA_ASSERT_IMP(label, pre, post, msg)
`endif
`endif

// ===== rtl/sga_pkg.sv =====
// ----------------------------------------------------------------------------
// sga_pkg
// Shared types and constants of the stereo goniometer accumulator.
// ----------------------------------------------------------------------------
package sga_pkg;

  localparam logic [1:0] ACT_DECAY = 2'd0;
  localparam logic [1:0] ACT_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [1:0] REG_DECAY = 2'd0;
  localparam logic [1:0] REG_BRIGHT = 2'd1;
  localparam logic [1:0] REG_INV = 2'd2;
  localparam logic [1:0] REG_SOFT = 2'd3;

  localparam logic [16:0] EDGE_START = 17'd55706;
  localparam logic [16:0] EDGE_SPAN = 17'd19661;
  // Ceiling of 2^45 / EDGE_SPAN; (x * EDGE_RECIP) >> 29 equals (x << 16) / EDGE_SPAN
  // exactly for every x below EDGE_SPAN.
  localparam logic [30:0] EDGE_RECIP = 31'd1789551503;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MATH,
    ST_DIV,
    ST_SPLAT,
    ST_DECAY,
    ST_READ,
    ST_OUT
  } sga_state_t;

  // Request from the controller to the cell memory.
  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    logic [19:0] rd_addr;
    logic [19:0] wr_addr;
    logic [15:0] wr_data;
  } sga_mem_req_t;

endpackage

// ===== rtl/sga_if.sv =====
// ----------------------------------------------------------------------------
// sga_in_if / sga_out_if / sga_cfg_if
// Valid/ready channels of the stereo goniometer accumulator.
// ----------------------------------------------------------------------------
interface sga_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic [7:0]        read_col;
  logic [7:0]        read_row;
  modport source (output valid, action, left_sample, right_sample, read_col, read_row,
                  input ready);
  modport sink (input valid, action, left_sample, right_sample, read_col, read_row,
                output ready);
endinterface

interface sga_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_value;
  modport source (output valid, cell_value, input ready);
  modport sink (input valid, cell_value, output ready);
endinterface

interface sga_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/sga_cell_mem.sv =====
// ----------------------------------------------------------------------------
// sga_cell_mem
// Single-port-write, single-port-read cell memory with registered read data.
// ----------------------------------------------------------------------------
module sga_cell_mem
  import sga_pkg::*;
#(
  parameter int ADDR_W = 16
) (
  input  logic         clk,
  input  sga_mem_req_t req,
  output logic [15:0]  rd_data
);

  logic [15:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[ADDR_W-1:0]] <= req.wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[ADDR_W-1:0]];
    end
  end

endmodule

// ===== rtl/stereo_goniometer_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// stereo_goniometer_accumulator_core
// Goniometer phosphor image held in a cell memory, with decay, splat and read.
// ----------------------------------------------------------------------------
// Usage: items arrive on the in_ channel, one transfer at a time, and the input
// is ready only while the block is idle, so every item passes through the idle
// state before the next is taken. Action 0 decays every cell, as the single
// memory read port visits each cell once; CELLS is GRID_SIZE rounded up to a
// power of two, squared. Action 1 takes a sample pair: arithmetic in the MATH
// state (cut short when the point falls off the grid), the edge fade in the DIV
// state when soften is set, and then the four read-modify-write updates in the
// SPLAT state. Action 2 reads one cell through the READ and OUT states and
// offers it on the out_ channel from the output register. A result held back
// by the receiver waits in the output register while other items go on; a
// further read then waits in its last stage, which holds off the input.
// Registers are to be written by the user on the cfg_ channel only while the
// block is idle; the block itself does not enforce this. After reset the block
// runs a clearing pass over all CELLS cells, one cell a cycle, and takes no
// input item until it ends; configuration transfers are taken throughout.
// ----------------------------------------------------------------------------
`include "stereo_goniometer_accumulator_core_assert.svh"

module stereo_goniometer_accumulator_core
  import sga_pkg::*;
#(
  parameter int GRID_SIZE = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  sga_in_if.sink     in_ch,
  sga_out_if.source  out_ch,
  sga_cfg_if.sink    cfg_ch
);

  localparam int CW = $clog2(GRID_SIZE);
  localparam int AW = 2 * CW;
  localparam int CELLS = 1 << AW;
  localparam logic [9:0] GMAX = 10'(GRID_SIZE - 1);

  // Configuration registers.
  logic [15:0] decay_r, bright_r, inv_r;
  logic [16:0] soft_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= 16'd58982;
      bright_r <= 16'd6554;
      inv_r <= 16'd4096;
      soft_r <= 17'd0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_DECAY: decay_r <= cfg_ch.data[15:0];
        REG_BRIGHT: bright_r <= cfg_ch.data[15:0];
        REG_INV: inv_r <= cfg_ch.data[15:0];
        REG_SOFT: soft_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Clamped register values.
  logic [15:0] d_c, b_c, i_c;
  logic [16:0] s_c;
  always_comb begin
    d_c = decay_r < 16'd52429 ? 16'd52429 : (decay_r > 16'd64881 ? 16'd64881 : decay_r);
    b_c = bright_r < 16'd655 ? 16'd655 : (bright_r > 16'd32768 ? 16'd32768 : bright_r);
    i_c = inv_r < 16'd2048 ? 16'd2048 : (inv_r > 16'd40960 ? 16'd40960 : inv_r);
    s_c = soft_r > 17'd65536 ? 17'd65536 : soft_r;
  end

  // State and working registers.
  sga_state_t  state_r, state_nxt;
  logic [4:0]  step_r;
  logic [AW:0] ptr_r;
  logic [AW:0] wptr_r;
  logic        wpend_r;
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic signed [17:0] side_r, mid_r;
  logic [16:0] amax_r;
  logic signed [35:0] ux_r, uy_r;
  logic [26:0] px_r, py_r;
  logic [32:0] edge_r;
  logic [16:0] t_r;
  logic [33:0] prod_r;
  logic [16:0] dot_r;
  logic [33:0] amt_r;
  logic [1:0]  k_r;
  logic [15:0] rd_data;
  sga_mem_req_t req;

  logic in_xfer;
  logic rd_oob;
  logic out_free;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign rd_oob = (11'(in_ch.read_col) >= 11'(GRID_SIZE)) ||
                  (11'(in_ch.read_row) >= 11'(GRID_SIZE));
  assign out_free = !out_valid_r || out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (ptr_r == (AW+1)'(CELLS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_ch.action)
            ACT_DECAY: state_nxt = ST_DECAY;
            ACT_SAMPLE: state_nxt = ST_MATH;
            ACT_READ: state_nxt = ST_READ;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MATH: begin
        if (step_r == 5'd3 && (ux_r < 0 || ux_r >= 36'sd536870912 ||
                               uy_r < 0 || uy_r >= 36'sd536870912)) state_nxt = ST_IDLE;
        else if (step_r == 5'd7) state_nxt = (s_c != 17'd0) ? ST_DIV : ST_SPLAT;
      end
      ST_DIV: if (step_r == 5'd5) state_nxt = ST_SPLAT;
      ST_SPLAT: if (k_r == 2'd3 && step_r == 5'd3) state_nxt = ST_IDLE;
      ST_DECAY: if (ptr_r == (AW+1)'(CELLS + 1)) state_nxt = ST_IDLE;
      ST_READ: state_nxt = ST_OUT;
      ST_OUT: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Splat cell coordinates and weights for the current corner.
  logic [10:0] cx, cy;
  logic [16:0] wx, wy;
  logic        cin;
  always_comb begin
    cx = 11'(px_r[26:16]) + 11'(k_r[0]);
    cy = 11'(py_r[26:16]) + 11'(k_r[1]);
    wx = k_r[0] ? {1'b0, px_r[15:0]} : 17'd65536 - {1'b0, px_r[15:0]};
    wy = k_r[1] ? {1'b0, py_r[15:0]} : 17'd65536 - {1'b0, py_r[15:0]};
    cin = (cx < 11'(GRID_SIZE)) && (cy < 11'(GRID_SIZE));
  end

  // Memory requests.
  logic [16:0] sat_sum;
  logic [31:0] dprod;
  always_comb begin
    req = '0;
    sat_sum = 17'(rd_data) + 17'(amt_r[16:0]);
    dprod = rd_data * d_c + 32'd32768;
    unique case (state_r)
      ST_CLEAR: begin
        req.wr_en = 1'b1;
        req.wr_addr = 20'(ptr_r[AW-1:0]);
      end
      ST_DECAY: begin
        req.rd_en = ptr_r < (AW+1)'(CELLS);
        req.rd_addr = 20'(ptr_r[AW-1:0]);
        req.wr_en = wpend_r;
        req.wr_addr = 20'(wptr_r[AW-1:0]);
        req.wr_data = dprod[31:16];
      end
      ST_READ: begin
        req.rd_en = 1'b1;
        req.rd_addr = 20'(ptr_r[AW-1:0]);
      end
      ST_SPLAT: begin
        req.rd_en = step_r == 5'd1 && cin;
        req.rd_addr = 20'({cy[CW-1:0], cx[CW-1:0]});
        req.wr_en = step_r == 5'd3 && cin;
        req.wr_addr = 20'({cy[CW-1:0], cx[CW-1:0]});
        req.wr_data = (amt_r > 34'd65535 || sat_sum[16]) ? 16'hFFFF : sat_sum[15:0];
      end
      default: ;
    endcase
  end

  sga_cell_mem #(.ADDR_W(AW)) u_mem (.clk(clk), .req(req), .rd_data(rd_data));

  // Distance past the start of the edge fade.
  logic [32:0] ediff;
  assign ediff = edge_r - 33'(EDGE_START);

  // Output register: loaded when a read reaches its last stage and the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Datapath and sequencing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ptr_r <= '0;
      step_r <= '0;
      wpend_r <= 1'b0;
      k_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_CLEAR: ptr_r <= ptr_r + 1'b1;
        ST_IDLE: begin
          step_r <= '0;
          k_r <= '0;
          wpend_r <= 1'b0;
          if (in_xfer && in_ch.action == ACT_READ)
            ptr_r <= {rd_oob, CW'(in_ch.read_row), CW'(in_ch.read_col)};
          else
            ptr_r <= '0;
          if (in_xfer) begin
            side_r <= 18'(in_ch.left_sample) - 18'(in_ch.right_sample);
            mid_r <= 18'(in_ch.left_sample) + 18'(in_ch.right_sample);
          end
        end
        ST_MATH: begin
          step_r <= (step_r == 5'd7) ? '0 : step_r + 1'b1;
          case (step_r)
            5'd0: begin
              amax_r <= 17'((side_r < 0 ? -side_r : side_r) >
                            (mid_r < 0 ? -mid_r : mid_r) ?
                            (side_r < 0 ? -side_r : side_r) : (mid_r < 0 ? -mid_r : mid_r));
            end
            5'd1: begin
              ux_r <= side_r * $signed({1'b0, i_c});
              uy_r <= -(mid_r * $signed({1'b0, i_c}));
              edge_r <= 33'((amax_r * i_c) >> 12);
            end
            5'd2: begin
              ux_r <= ux_r + 36'sd268435456;
              uy_r <= uy_r + 36'sd268435456;
            end
            5'd3: begin
              px_r <= 27'((39'(ux_r[28:0]) * 39'(GMAX)) >> 13);
              py_r <= 27'((39'(uy_r[28:0]) * 39'(GMAX)) >> 13);
              dot_r <= 17'(b_c);
              if (edge_r <= 33'(EDGE_START)) t_r <= 17'd0;
              else if (edge_r - 33'(EDGE_START) >= 33'(EDGE_SPAN)) t_r <= 17'd65536;
              else t_r <= '0;
            end
            default: ;
          endcase
        end
        ST_DIV: begin
          // Fade ramp by reciprocal multiplication, then the smoothstep and the fade.
          step_r <= (step_r == 5'd5) ? '0 : step_r + 1'b1;
          case (step_r)
            5'd0: if (edge_r > 33'(EDGE_START) && ediff < 33'(EDGE_SPAN))
                    t_r <= 17'((46'(ediff[14:0]) * 46'(EDGE_RECIP)) >> 29);
            5'd1: prod_r <= 34'((t_r * t_r) >> 16);
            5'd2: prod_r <= 34'((prod_r[16:0] * (18'd196608 - 18'({t_r, 1'b0}))) >> 16);
            5'd3: prod_r <= 34'((s_c * prod_r[16:0]) >> 16);
            5'd4: prod_r <= 34'(17'd65536 - prod_r[16:0]);
            5'd5: dot_r <= 17'((34'(b_c) * 34'(prod_r[16:0])) >> 16);
            default: ;
          endcase
        end
        ST_SPLAT: begin
          step_r <= (step_r == 5'd3) ? '0 : step_r + 1'b1;
          case (step_r)
            5'd0: prod_r <= 34'(dot_r * wx);
            5'd1: amt_r <= 34'((51'(prod_r) * wy) >> 32);
            default: ;
          endcase
          if (step_r == 5'd3) k_r <= k_r + 1'b1;
        end
        ST_DECAY: begin
          ptr_r <= ptr_r + 1'b1;
          wptr_r <= ptr_r;
          wpend_r <= ptr_r < (AW+1)'(CELLS);
        end
        ST_READ: ;
        ST_OUT: begin
          if (out_free) out_data_r <= ptr_r[AW] ? 16'd0 : rd_data;
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.cell_value = out_data_r;

  `SGA_ASSERT_IMP(a_out_stable, out_valid_r && !out_ch.ready, $stable(out_data_r), "result changed while held")
  `SGA_ASSERT_IMP(a_out_holds, out_valid_r && !out_ch.ready, out_valid_r, "result dropped")
  `SGA_ASSERT(a_clear_no_in, !(state_r == ST_CLEAR && in_ch.ready), "input during clear")

endmodule
